>>> src/abd_pkg.sv
// ----------------------------------------------------------------------------
// abd_pkg: shared constants and tables of the anchor box decoder
// Field widths, register indexes, reset values and the exp tables in Q8.24.
// ----------------------------------------------------------------------------
package abd_pkg;

	// Stream payload
	localparam int IN_W       = 16;
	localparam int NUM_IN     = 5;
	localparam int IN_DATA_W  = IN_W * NUM_IN;
	localparam int CORNER_W   = 14;
	localparam int CONF_W     = 16;
	localparam int OUT_DATA_W = 4 * CORNER_W + CONF_W;

	// Configuration registers
	localparam int GRID_REG_W    = 9;
	localparam int STRIDE_W      = 7;
	localparam int ANCHOR_W      = 26;
	localparam int ANCHOR_W_BITS = 10;
	localparam int ANCHOR_H_BITS = 16;
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 26;

	localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STRIDE_X    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_STRIDE_Y    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ANCHOR_ZERO = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_ANCHOR_ONE  = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_ANCHOR_TWO  = 3'd6;

	localparam logic [GRID_REG_W-1:0] RST_GRID_WIDTH  = 9'd13;
	localparam logic [GRID_REG_W-1:0] RST_GRID_HEIGHT = 9'd13;
	localparam logic [STRIDE_W-1:0]   RST_STRIDE_X    = 7'd32;
	localparam logic [STRIDE_W-1:0]   RST_STRIDE_Y    = 7'd32;
	localparam logic [ANCHOR_W-1:0]   RST_ANCHOR_ZERO = 26'd7602266;
	localparam logic [ANCHOR_W-1:0]   RST_ANCHOR_ONE  = 26'd10223814;
	localparam logic [ANCHOR_W-1:0]   RST_ANCHOR_TWO  = 26'd24445254;

	// Top level parameter defaults
	localparam int DEF_MAX_GRID         = 256;
	localparam int DEF_ANCHORS_PER_CELL = 3;

	// Exp and sigmoid arithmetic
	localparam int EXP_W     = 30;  // Q8.24, never above e^4
	localparam int PART_W    = 25;
	localparam int EXP_Q     = 24;
	localparam int EXP_STEPS = 10;  // one product per fraction bit of Q5.10
	localparam int ARG_W     = 17;
	localparam int U_W       = 15;
	localparam int ARG_BIAS  = 16384;
	localparam int ARG_LIMIT = 16384;
	localparam int SIZE_MIN  = -8192;
	localparam int SIZE_MAX  = 4096;
	localparam int SIG_W     = 17;  // sigmoid 0..65536
	localparam int SIG_ONE   = 65536;
	localparam int DIV_W     = 26;
	localparam int DIV_STEPS = SIG_W;
	localparam int LANE_LAT  = 1 + EXP_STEPS + DIV_STEPS + 1;

	// Box arithmetic, centre and size in Q.25
	localparam int POS_FRAC     = 25;
	localparam int CENTER_SHIFT = POS_FRAC - CONF_W;
	localparam int CORNER_MIN   = -(2 ** (CORNER_W - 1));
	localparam int CORNER_MAX   = 2 ** (CORNER_W - 1) - 1;

	// e^n in Q8.24 for n = -16 .. 4, indexed by n + 16
	function automatic logic [EXP_W-1:0] exp_whole(input logic [4:0] n);
		logic [EXP_W-1:0] r;
		unique case (n)
			5'd0:    r = 30'd2;
			5'd1:    r = 30'd5;
			5'd2:    r = 30'd14;
			5'd3:    r = 30'd38;
			5'd4:    r = 30'd103;
			5'd5:    r = 30'd280;
			5'd6:    r = 30'd762;
			5'd7:    r = 30'd2070;
			5'd8:    r = 30'd5628;
			5'd9:    r = 30'd15299;
			5'd10:   r = 30'd41587;
			5'd11:   r = 30'd113044;
			5'd12:   r = 30'd307285;
			5'd13:   r = 30'd835288;
			5'd14:   r = 30'd2270549;
			5'd15:   r = 30'd6171993;
			5'd16:   r = 30'd16777216;
			5'd17:   r = 30'd45605201;
			5'd18:   r = 30'd123967790;
			5'd19:   r = 30'd336979391;
			default: r = 30'd916004956;
		endcase
		return r;
	endfunction

	// e^(2^-(k+1)) in Q8.24
	function automatic logic [PART_W-1:0] exp_part(input logic [3:0] k);
		logic [PART_W-1:0] r;
		unique case (k)
			4'd0:    r = 25'd27660953;
			4'd1:    r = 25'd21542372;
			4'd2:    r = 25'd19011076;
			4'd3:    r = 25'd17859253;
			4'd4:    r = 25'd17309782;
			4'd5:    r = 25'd17041419;
			4'd6:    r = 25'd16908801;
			4'd7:    r = 25'd16842880;
			4'd8:    r = 25'd16810016;
			default: r = 25'd16793608;
		endcase
		return r;
	endfunction

endpackage

>>> src/abd_lane.sv
// ----------------------------------------------------------------------------
// abd_lane: pipelined exp or sigmoid of one Q5.10 value
// A table stage, ten rounded table products and, in sigmoid mode, a
// restoring divider that retires one quotient bit per stage.
// ----------------------------------------------------------------------------
module abd_lane #(
	parameter bit SIGMOID = 1'b1
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [abd_pkg::IN_W-1:0]   x,
	output logic        [abd_pkg::EXP_W-1:0]  result
);

	localparam int EXP_W     = abd_pkg::EXP_W;
	localparam int EXP_STEPS = abd_pkg::EXP_STEPS;
	localparam int PROD_W    = abd_pkg::EXP_W + abd_pkg::PART_W;
	localparam int DIV_W     = abd_pkg::DIV_W;
	localparam int DIV_STEPS = abd_pkg::DIV_STEPS;
	localparam int SIG_W     = abd_pkg::SIG_W;
	localparam int U_W       = abd_pkg::U_W;
	localparam int FRAC_B    = EXP_STEPS;

	logic signed [abd_pkg::ARG_W-1:0] xe;
	logic        [abd_pkg::ARG_W-1:0] mag;
	logic        [U_W-1:0]            u;

	// Index _s[k] holds the value after k table products.
	logic [EXP_W-1:0]  exp_r_s [EXP_STEPS+1];
	logic [FRAC_B-1:0] exp_f_s [EXP_STEPS];

	// Biased argument: the sigmoid uses exp(-min(|x|,16)), the size term exp(clamp(x)).
	always_comb begin
		xe  = {x[abd_pkg::IN_W-1], x};
		mag = abd_pkg::ARG_W'(x[abd_pkg::IN_W-1] ? -xe : xe);
		if (mag > abd_pkg::ARG_W'(abd_pkg::ARG_LIMIT)) begin
			mag = abd_pkg::ARG_W'(abd_pkg::ARG_LIMIT);
		end
		if (SIGMOID) begin
			u = U_W'(abd_pkg::ARG_W'(abd_pkg::ARG_BIAS) - mag);
		end else if (xe < abd_pkg::ARG_W'(abd_pkg::SIZE_MIN)) begin
			u = U_W'(abd_pkg::SIZE_MIN + abd_pkg::ARG_BIAS);
		end else if (xe > abd_pkg::ARG_W'(abd_pkg::SIZE_MAX)) begin
			u = U_W'(abd_pkg::SIZE_MAX + abd_pkg::ARG_BIAS);
		end else begin
			u = U_W'(xe + abd_pkg::ARG_W'(abd_pkg::ARG_BIAS));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			exp_r_s[0] <= abd_pkg::exp_whole(u[U_W-1:FRAC_B]);
			exp_f_s[0] <= u[FRAC_B-1:0];
		end
	end

	for (genvar k = 1; k <= EXP_STEPS; k++) begin : g_mul
		logic [PROD_W-1:0] prod;
		logic              use_bit;

		always_comb begin
			prod = PROD_W'(exp_r_s[k-1]) * PROD_W'(abd_pkg::exp_part(4'(k - 1)))
			     + PROD_W'(2 ** (abd_pkg::EXP_Q - 1));
			use_bit = exp_f_s[k-1][EXP_STEPS-k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				exp_r_s[k] <= use_bit ? prod[abd_pkg::EXP_Q +: EXP_W] : exp_r_s[k-1];
			end
		end

		if (k < EXP_STEPS) begin : g_frac
			always_ff @(posedge clk) begin
				if (en) begin
					exp_f_s[k] <= exp_f_s[k-1];
				end
			end
		end
	end

	if (SIGMOID) begin : g_sigmoid
		logic             neg_s     [EXP_STEPS+1];
		logic [DIV_W-1:0] div_rem_s [DIV_STEPS-1];
		logic [SIG_W-1:0] div_low_s [DIV_STEPS-1];
		logic [DIV_W-1:0] div_d_s   [DIV_STEPS-1];
		logic [SIG_W-1:0] div_q_s   [DIV_STEPS];
		logic             div_neg_s [DIV_STEPS];
		logic [SIG_W-1:0] sig_s;
		logic [SIG_W-1:0] sat;

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[0] <= x[abd_pkg::IN_W-1];
				for (int i = 1; i <= EXP_STEPS; i++) begin
					neg_s[i] <= neg_s[i-1];
				end
			end
		end

		// Quotient of (2^40 + d/2) / d with d = 2^24 + exp(-|x|); it lies in [2^15, 2^16].
		for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
			logic [DIV_W-1:0] rem_in;
			logic [DIV_W-1:0] d_in;
			logic [SIG_W-1:0] low_in;
			logic [SIG_W-1:0] q_in;
			logic             neg_in;
			logic [DIV_W-1:0] trial;
			logic             take;

			if (j == 0) begin : g_first
				always_comb begin
					d_in   = exp_r_s[EXP_STEPS][DIV_W-1:0] + DIV_W'(2 ** abd_pkg::EXP_Q);
					rem_in = DIV_W'(2 ** (abd_pkg::EXP_Q - 1)) | DIV_W'(d_in[DIV_W-1:SIG_W+1]);
					low_in = d_in[SIG_W:1];
					q_in   = '0;
					neg_in = neg_s[EXP_STEPS];
				end
			end else begin : g_next
				always_comb begin
					d_in   = div_d_s[j-1];
					rem_in = div_rem_s[j-1];
					low_in = div_low_s[j-1];
					q_in   = div_q_s[j-1];
					neg_in = div_neg_s[j-1];
				end
			end

			always_comb begin
				trial = {rem_in[DIV_W-2:0], low_in[SIG_W-1]};
				take  = trial >= d_in;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					div_q_s[j]   <= {q_in[SIG_W-2:0], take};
					div_neg_s[j] <= neg_in;
				end
			end

			if (j < DIV_STEPS - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (en) begin
						div_rem_s[j] <= take ? trial - d_in : trial;
						div_low_s[j] <= {low_in[SIG_W-2:0], 1'b0};
						div_d_s[j]   <= d_in;
					end
				end
			end
		end

		always_comb begin
			sat = div_q_s[DIV_STEPS-1];
			if (sat > SIG_W'(abd_pkg::SIG_ONE)) begin
				sat = SIG_W'(abd_pkg::SIG_ONE);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sig_s <= div_neg_s[DIV_STEPS-1] ? SIG_W'(abd_pkg::SIG_ONE) - sat : sat;
			end
		end

		assign result = EXP_W'(sig_s);
	end else begin : g_exp
		// Delay the exp to the latency of the sigmoid lanes.
		logic [EXP_W-1:0] dly_s [DIV_STEPS+1];

		always_ff @(posedge clk) begin
			if (en) begin
				dly_s[0] <= exp_r_s[EXP_STEPS];
				for (int i = 1; i <= DIV_STEPS; i++) begin
					dly_s[i] <= dly_s[i-1];
				end
			end
		end

		assign result = dly_s[DIV_STEPS];
	end

endmodule

>>> src/anchor_box_decoder.sv
// ----------------------------------------------------------------------------
// anchor_box_decoder: box decoding of one detector output scale
// Turns raw per-anchor predictions into pixel box corners and a confidence.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents (lowest bits first)
//  s_*      in         raw_x, raw_y, raw_w, raw_h, raw_objectness, Q5.10 each
//  m_*      out        left, top, right, bottom, confidence; last on m_tlast
//  cfg_*    in         register write: index 0..6, data up to 26 bits
//
//  One transaction per cycle in and out unless the output stalls; latency
//  follows the ten exp table products and the 17-stage sigmoid quotient.
//  A stalled output holds the whole pipeline; a skid register still takes
//  one more transaction. Reset clears the position counters and loads the
//  default grid, strides and anchors; there is no clearing pass.
// ----------------------------------------------------------------------------
module anchor_box_decoder #(
	parameter int MAX_GRID         = abd_pkg::DEF_MAX_GRID,
	parameter int ANCHORS_PER_CELL = abd_pkg::DEF_ANCHORS_PER_CELL
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// raw_x, raw_y, raw_w, raw_h, raw_objectness
	input  logic [abd_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// left, top, right, bottom, confidence
	output logic [abd_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                               m_tlast,
	input  logic                               cfg_write,
	input  logic [abd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [abd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CW   = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
	localparam int AW   = (ANCHORS_PER_CELL > 1) ? $clog2(ANCHORS_PER_CELL) : 1;
	localparam int LW   = (CW + 1 > abd_pkg::GRID_REG_W) ? CW + 1 : abd_pkg::GRID_REG_W;
	localparam int IW   = 2 * CW + AW + 1;
	localparam int LAT  = abd_pkg::LANE_LAT;
	localparam int IN_W = abd_pkg::IN_W;
	localparam int BW   = CW + abd_pkg::CONF_W + 1;
	localparam int CXW  = BW + abd_pkg::STRIDE_W;
	localparam int HWW  = abd_pkg::EXP_W + abd_pkg::ANCHOR_W_BITS;
	localparam int HHW  = abd_pkg::EXP_W + abd_pkg::ANCHOR_H_BITS;
	localparam int CSW  = CXW + abd_pkg::CENTER_SHIFT;
	localparam int VW   = ((CSW > HHW) ? CSW : HHW) + 2;
	localparam int QW   = VW - abd_pkg::POS_FRAC + 1;
	localparam int CRW  = abd_pkg::CORNER_W;

	// Configuration registers
	logic [abd_pkg::GRID_REG_W-1:0] grid_width_q;
	logic [abd_pkg::GRID_REG_W-1:0] grid_height_q;
	logic [abd_pkg::STRIDE_W-1:0]   stride_x_q;
	logic [abd_pkg::STRIDE_W-1:0]   stride_y_q;
	logic [abd_pkg::ANCHOR_W-1:0]   anchor_zero_q;
	logic [abd_pkg::ANCHOR_W-1:0]   anchor_one_q;
	logic [abd_pkg::ANCHOR_W-1:0]   anchor_two_q;

	// Position counters
	logic [CW-1:0] col_q;
	logic [CW-1:0] row_q;
	logic [AW-1:0] anc_q;

	logic [LW-1:0] gw;
	logic [LW-1:0] gh;
	logic [LW-1:0] col_inc;
	logic [LW-1:0] row_inc;
	logic          last_now;
	logic [IW-1:0] info_now;

	logic          en;
	logic          accept;

	logic                          skid_valid_q;
	logic [abd_pkg::IN_DATA_W-1:0] skid_data_q;
	logic [IW-1:0]                 skid_info_q;

	logic                          valid_s1;
	logic [abd_pkg::IN_DATA_W-1:0] raw_s1;
	logic [IW-1:0]                 info_s1;

	logic                          vld_s  [LAT];
	logic [IW-1:0]                 info_s [LAT];

	logic [abd_pkg::EXP_W-1:0] lane_x;
	logic [abd_pkg::EXP_W-1:0] lane_y;
	logic [abd_pkg::EXP_W-1:0] lane_w;
	logic [abd_pkg::EXP_W-1:0] lane_h;
	logic [abd_pkg::EXP_W-1:0] lane_obj;

	// Multiply stage
	logic [CW-1:0]                col_m;
	logic [CW-1:0]                row_m;
	logic [AW-1:0]                anc_m;
	logic [abd_pkg::ANCHOR_W-1:0] anchor_m;
	logic [BW-1:0]                base_x;
	logic [BW-1:0]                base_y;

	logic                       valid_s31;
	logic                       last_s31;
	logic [CXW-1:0]             cx_s31;
	logic [CXW-1:0]             cy_s31;
	logic [HWW-1:0]             hw_s31;
	logic [HHW-1:0]             hh_s31;
	logic [abd_pkg::CONF_W-1:0] conf_s31;

	// Add stage
	logic                       valid_s32;
	logic                       last_s32;
	logic signed [VW-1:0]       left_s32;
	logic signed [VW-1:0]       top_s32;
	logic signed [VW-1:0]       right_s32;
	logic signed [VW-1:0]       bottom_s32;
	logic [abd_pkg::CONF_W-1:0] conf_s32;

	logic                          out_valid_q;
	logic                          out_last_q;
	logic [abd_pkg::OUT_DATA_W-1:0] out_data_q;

	// Round to nearest with ties to even, then saturate to the corner range.
	function automatic logic [CRW-1:0] corner(input logic signed [VW-1:0] v);
		logic signed [QW-1:0]            q;
		logic [abd_pkg::POS_FRAC-1:0]    frac;
		logic                            up;
		q    = QW'(v >>> abd_pkg::POS_FRAC);
		frac = v[abd_pkg::POS_FRAC-1:0];
		up   = (frac > abd_pkg::POS_FRAC'(2 ** (abd_pkg::POS_FRAC - 1)))
		    || ((frac == abd_pkg::POS_FRAC'(2 ** (abd_pkg::POS_FRAC - 1))) && q[0]);
		q    = q + $signed({{(QW - 1){1'b0}}, up});
		if (q < QW'(abd_pkg::CORNER_MIN)) begin
			q = QW'(abd_pkg::CORNER_MIN);
		end else if (q > QW'(abd_pkg::CORNER_MAX)) begin
			q = QW'(abd_pkg::CORNER_MAX);
		end
		return q[CRW-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= abd_pkg::RST_GRID_WIDTH;
			grid_height_q <= abd_pkg::RST_GRID_HEIGHT;
			stride_x_q    <= abd_pkg::RST_STRIDE_X;
			stride_y_q    <= abd_pkg::RST_STRIDE_Y;
			anchor_zero_q <= abd_pkg::RST_ANCHOR_ZERO;
			anchor_one_q  <= abd_pkg::RST_ANCHOR_ONE;
			anchor_two_q  <= abd_pkg::RST_ANCHOR_TWO;
		end else if (cfg_write) begin
			unique case (cfg_index)
				abd_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_data[abd_pkg::GRID_REG_W-1:0];
				abd_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_data[abd_pkg::GRID_REG_W-1:0];
				abd_pkg::REG_STRIDE_X:    stride_x_q    <= cfg_data[abd_pkg::STRIDE_W-1:0];
				abd_pkg::REG_STRIDE_Y:    stride_y_q    <= cfg_data[abd_pkg::STRIDE_W-1:0];
				abd_pkg::REG_ANCHOR_ZERO: anchor_zero_q <= cfg_data[abd_pkg::ANCHOR_W-1:0];
				abd_pkg::REG_ANCHOR_ONE:  anchor_one_q  <= cfg_data[abd_pkg::ANCHOR_W-1:0];
				abd_pkg::REG_ANCHOR_TWO:  anchor_two_q  <= cfg_data[abd_pkg::ANCHOR_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Grid position of the transaction being accepted
	// ------------------------------------------------------------------
	always_comb begin
		if (grid_width_q == '0) begin
			gw = LW'(1);
		end else if (LW'(grid_width_q) > LW'(MAX_GRID)) begin
			gw = LW'(MAX_GRID);
		end else begin
			gw = LW'(grid_width_q);
		end
		if (grid_height_q == '0) begin
			gh = LW'(1);
		end else if (LW'(grid_height_q) > LW'(MAX_GRID)) begin
			gh = LW'(MAX_GRID);
		end else begin
			gh = LW'(grid_height_q);
		end
		col_inc  = LW'(col_q) + LW'(1);
		row_inc  = LW'(row_q) + LW'(1);
		last_now = (anc_q == AW'(ANCHORS_PER_CELL - 1))
		        && (LW'(col_q) == gw - LW'(1))
		        && (LW'(row_q) == gh - LW'(1));
		info_now = {last_now, anc_q, row_q, col_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			anc_q <= '0;
		end else if (accept) begin
			if (anc_q == AW'(ANCHORS_PER_CELL - 1)) begin
				anc_q <= '0;
				if (col_inc >= gw) begin
					col_q <= '0;
					if (row_inc >= gh) begin
						row_q <= '0;
					end else begin
						row_q <= row_inc[CW-1:0];
					end
				end else begin
					col_q <= col_inc[CW-1:0];
				end
			end else begin
				anc_q <= anc_q + AW'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Handshake and pipeline valids
	// ------------------------------------------------------------------
	assign en       = !out_valid_q || m_tready;
	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
			valid_s1     <= 1'b0;
			for (int i = 0; i < LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
			valid_s31   <= 1'b0;
			valid_s32   <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			skid_valid_q <= 1'b0;
			valid_s1     <= skid_valid_q || accept;
			vld_s[0]     <= valid_s1;
			for (int i = 1; i < LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
			valid_s31   <= vld_s[LAT-1];
			valid_s32   <= valid_s31;
			out_valid_q <= valid_s32;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !en) begin
			skid_data_q <= s_tdata;
			skid_info_q <= info_now;
		end
		if (en) begin
			raw_s1  <= skid_valid_q ? skid_data_q : s_tdata;
			info_s1 <= skid_valid_q ? skid_info_q : info_now;
			info_s[0] <= info_s1;
			for (int i = 1; i < LAT; i++) begin
				info_s[i] <= info_s[i-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Function lanes
	// ------------------------------------------------------------------
	abd_lane #(.SIGMOID(1'b1)) u_lane_x (
		.clk(clk), .en(en), .x(raw_s1[0*IN_W +: IN_W]), .result(lane_x)
	);
	abd_lane #(.SIGMOID(1'b1)) u_lane_y (
		.clk(clk), .en(en), .x(raw_s1[1*IN_W +: IN_W]), .result(lane_y)
	);
	abd_lane #(.SIGMOID(1'b0)) u_lane_w (
		.clk(clk), .en(en), .x(raw_s1[2*IN_W +: IN_W]), .result(lane_w)
	);
	abd_lane #(.SIGMOID(1'b0)) u_lane_h (
		.clk(clk), .en(en), .x(raw_s1[3*IN_W +: IN_W]), .result(lane_h)
	);
	abd_lane #(.SIGMOID(1'b1)) u_lane_obj (
		.clk(clk), .en(en), .x(raw_s1[4*IN_W +: IN_W]), .result(lane_obj)
	);

	// ------------------------------------------------------------------
	// Centre and half size
	// ------------------------------------------------------------------
	always_comb begin
		col_m  = info_s[LAT-1][CW-1:0];
		row_m  = info_s[LAT-1][2*CW-1:CW];
		anc_m  = info_s[LAT-1][2*CW+AW-1:2*CW];
		if (anc_m == AW'(0)) begin
			anchor_m = anchor_zero_q;
		end else if (anc_m == AW'(1)) begin
			anchor_m = anchor_one_q;
		end else begin
			anchor_m = anchor_two_q;
		end
		base_x = BW'({col_m, {abd_pkg::CONF_W{1'b0}}}) + BW'(lane_x[abd_pkg::SIG_W-1:0]);
		base_y = BW'({row_m, {abd_pkg::CONF_W{1'b0}}}) + BW'(lane_y[abd_pkg::SIG_W-1:0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s31 <= info_s[LAT-1][IW-1];
			cx_s31   <= CXW'(base_x) * CXW'(stride_x_q);
			cy_s31   <= CXW'(base_y) * CXW'(stride_y_q);
			hw_s31   <= HWW'(lane_w) * HWW'(anchor_m[abd_pkg::ANCHOR_W-1:abd_pkg::ANCHOR_H_BITS]);
			hh_s31   <= HHW'(lane_h) * HHW'(anchor_m[abd_pkg::ANCHOR_H_BITS-1:0]);
			// A sigmoid of exactly one does not fit Q0.16.
			conf_s31 <= lane_obj[abd_pkg::CONF_W] ? {abd_pkg::CONF_W{1'b1}}
			                                      : lane_obj[abd_pkg::CONF_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Corners in Q.25, then rounding into the output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			last_s32   <= last_s31;
			conf_s32   <= conf_s31;
			left_s32   <= $signed(VW'({cx_s31, {abd_pkg::CENTER_SHIFT{1'b0}}}))
			            - $signed(VW'(hw_s31));
			right_s32  <= $signed(VW'({cx_s31, {abd_pkg::CENTER_SHIFT{1'b0}}}))
			            + $signed(VW'(hw_s31));
			top_s32    <= $signed(VW'({cy_s31, {abd_pkg::CENTER_SHIFT{1'b0}}}))
			            - $signed(VW'(hh_s31));
			bottom_s32 <= $signed(VW'({cy_s31, {abd_pkg::CENTER_SHIFT{1'b0}}}))
			            + $signed(VW'(hh_s31));
			out_last_q <= last_s32;
			out_data_q <= {conf_s32, corner(bottom_s32), corner(right_s32),
			               corner(top_s32), corner(left_s32)};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

>>> sim/anchor_box_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// anchor_box_decoder_tb: self-checking bench of the anchor box decoder
// A short table of directed predictions runs first. It is followed by
// phases of random predictions under several grid, stride and anchor
// settings. Every box that leaves the block is compared with the table's
// box for typed rows, else with a bit-exact fixed-point bench decoder.
// ----------------------------------------------------------------------------
module anchor_box_decoder_tb;
	import abd_pkg::*;

	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 40;
	localparam int LIMIT_CYCLES = 200000;
	localparam int MAX_REPORTS  = 40;
	localparam logic [ANCHOR_W-1:0] ANCHOR_TOP = 26'd67044351;

	typedef enum logic [1:0] {PACE_RECV_HEAVY, PACE_SEND_HEAVY, PACE_FREE} pacing_t;

	typedef struct packed {
		logic signed [CORNER_W-1:0] left;
		logic signed [CORNER_W-1:0] top;
		logic signed [CORNER_W-1:0] right;
		logic signed [CORNER_W-1:0] bottom;
		logic [CONF_W-1:0]          confidence;
		logic                       last;
	} box_t;

	typedef struct packed {
		logic signed [IN_W-1:0] x;
		logic signed [IN_W-1:0] y;
		logic signed [IN_W-1:0] w;
		logic signed [IN_W-1:0] h;
		logic signed [IN_W-1:0] obj;
		logic                   typed;
		box_t                   want;
	} stim_row_t;

	typedef struct packed {
		logic [GRID_REG_W-1:0] grid_w;
		logic [GRID_REG_W-1:0] grid_h;
		logic [STRIDE_W-1:0]   stride_x;
		logic [STRIDE_W-1:0]   stride_y;
		logic [ANCHOR_W-1:0]   anchor0;
		logic [ANCHOR_W-1:0]   anchor1;
		logic [ANCHOR_W-1:0]   anchor2;
		logic                  random_anchors;
		logic [15:0]           items;
		pacing_t               pacing;
		logic                  hold;
	} phase_t;

	// The first three rows decode with the reset settings at cell zero, so the
	// boxes follow directly from the default anchors and a centre of 16 pixels.
	localparam int DIR_N = 16;
	localparam stim_row_t DIRECTED [DIR_N] = '{
		'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			'{-14'sd42, -14'sd29, 14'sd74, 14'sd61, 16'd32768, 1'b0}},
		'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			'{-14'sd62, -14'sd83, 14'sd94, 14'sd115, 16'd32768, 1'b0}},
		'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			'{-14'sd170, -14'sd147, 14'sd202, 14'sd179, 16'd32768, 1'b0}},
		'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0},
		'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, '0},
		'{16'h4000, 16'hC000, 16'h1000, 16'h1000, 16'h4000, 1'b0, '0},
		'{16'h4001, 16'hBFFF, 16'h1001, 16'hDFFF, 16'hBFFF, 1'b0, '0},
		'{16'hFFFF, 16'h0001, 16'hE000, 16'hE000, 16'h0001, 1'b0, '0},
		'{16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF, 1'b0, '0},
		'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, '0},
		'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, '0},
		'{16'h03FF, 16'hFC01, 16'h03FF, 16'hFC01, 16'h0400, 1'b0, '0},
		'{16'h0200, 16'hFE00, 16'h0C00, 16'hF000, 16'hFE00, 1'b0, '0},
		'{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 1'b0, '0},
		'{16'h8000, 16'h7FFF, 16'h1001, 16'hDFFF, 16'h7FFF, 1'b0, '0},
		'{16'h2000, 16'hE000, 16'hF800, 16'h0800, 16'hC000, 1'b0, '0}
	};

	// Grid sizes of 0 and 511 exercise the clamp; a phase that shrinks the grid
	// starts while the position counters still sit beyond the new bounds.
	localparam int PHASE_N = 8;
	localparam phase_t PHASES [PHASE_N] = '{
		'{9'd2, 9'd2, 7'd32, 7'd32, RST_ANCHOR_ZERO, RST_ANCHOR_ONE, RST_ANCHOR_TWO,
			1'b0, 16'd100, PACE_RECV_HEAVY, 1'b0},
		'{9'd0, 9'd511, 7'd64, 7'd1, 26'd0, ANCHOR_TOP, 26'd33554431,
			1'b0, 16'd80, PACE_RECV_HEAVY, 1'b0},
		'{9'd5, 9'd4, 7'd1, 7'd64, 26'd0, 26'd0, 26'd0,
			1'b1, 16'd100, PACE_RECV_HEAVY, 1'b0},
		'{9'd1, 9'd0, 7'd0, 7'd0, 26'd0, 26'd0, 26'd0,
			1'b1, 16'd80, PACE_SEND_HEAVY, 1'b0},
		'{9'd13, 9'd13, 7'd32, 7'd32, RST_ANCHOR_ZERO, RST_ANCHOR_ONE, RST_ANCHOR_TWO,
			1'b0, 16'd120, PACE_SEND_HEAVY, 1'b1},
		'{9'd256, 9'd3, 7'd17, 7'd9, 26'd0, 26'd0, 26'd0,
			1'b1, 16'd60, PACE_SEND_HEAVY, 1'b0},
		'{9'd1, 9'd256, 7'd64, 7'd64, ANCHOR_TOP, 26'd65535, 26'd66977792,
			1'b0, 16'd780, PACE_FREE, 1'b0},
		'{9'd3, 9'd2, 7'd127, 7'd127, 26'd0, 26'd0, 26'd0,
			1'b1, 16'd60, PACE_FREE, 1'b0}
	};

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	// raw_x, raw_y, raw_w, raw_h, raw_objectness
	logic [IN_DATA_W-1:0]    s_tdata   = '0;
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	// left, top, right, bottom, confidence
	logic [OUT_DATA_W-1:0]   m_tdata;
	logic                    m_tlast;
	logic                    cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data  = '0;

	// Decoder settings and position as the bench sees them.
	logic [GRID_REG_W-1:0] grid_w_reg   = RST_GRID_WIDTH;
	logic [GRID_REG_W-1:0] grid_h_reg   = RST_GRID_HEIGHT;
	logic [STRIDE_W-1:0]   stride_x_reg = RST_STRIDE_X;
	logic [STRIDE_W-1:0]   stride_y_reg = RST_STRIDE_Y;
	logic [ANCHOR_W-1:0]   anchor_reg [3] = '{RST_ANCHOR_ZERO, RST_ANCHOR_ONE, RST_ANCHOR_TWO};
	int                    col_pos    = 0;
	int                    row_pos    = 0;
	int                    anchor_pos = 0;

	box_t box_q [$];
	int   errors        = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic hold_kick     = 1'b0;
	logic hold_seen     = 1'b0;
	int   hold_left     = 0;
	logic row_typed     = 1'b0;
	box_t row_want      = '0;

	anchor_box_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// e^n in Q8.24, indexed by n + 16
	function automatic longint unsigned exp_whole_q24(int unsigned n);
		case (n)
			0:       return 2;
			1:       return 5;
			2:       return 14;
			3:       return 38;
			4:       return 103;
			5:       return 280;
			6:       return 762;
			7:       return 2070;
			8:       return 5628;
			9:       return 15299;
			10:      return 41587;
			11:      return 113044;
			12:      return 307285;
			13:      return 835288;
			14:      return 2270549;
			15:      return 6171993;
			16:      return 16777216;
			17:      return 45605201;
			18:      return 123967790;
			19:      return 336979391;
			default: return 916004956;
		endcase
	endfunction

	// e^(2^-(k+1)) in Q8.24
	function automatic longint unsigned exp_frac_q24(int k);
		case (k)
			0:       return 27660953;
			1:       return 21542372;
			2:       return 19011076;
			3:       return 17859253;
			4:       return 17309782;
			5:       return 17041419;
			6:       return 16908801;
			7:       return 16842880;
			8:       return 16810016;
			default: return 16793608;
		endcase
	endfunction

	// Q5.10 argument to Q8.24, one rounded product per set fraction bit.
	function automatic longint unsigned exp_fixed(int t);
		int unsigned     u;
		int unsigned     n;
		int unsigned     f;
		longint unsigned r;
		if (t < -16384) t = -16384;
		if (t > 4096) t = 4096;
		u = t + 16384;
		n = u >> 10;
		f = u & 1023;
		if (n > 20) n = 20;
		r = exp_whole_q24(n);
		for (int k = 0; k < 10; k++)
			if ((f & (512 >> k)) != 0)
				r = (r * exp_frac_q24(k) + (64'd1 << 23)) >> 24;
		return r;
	endfunction

	// Unsaturated Q0.16 logistic, 0 .. 65536.
	function automatic longint unsigned logistic_q16(int x);
		int              a;
		longint unsigned d;
		longint unsigned s;
		a = (x < 0) ? -x : x;
		if (a > 16384) a = 16384;
		d = (64'd1 << 24) + exp_fixed(-a);
		s = ((64'd1 << 40) + (d >> 1)) / d;
		if (s > 65536) s = 65536;
		return (x < 0) ? 64'd65536 - s : s;
	endfunction

	// Q.25 to whole pixels, ties to even, saturated to the corner width.
	function automatic logic [CORNER_W-1:0] round_corner(longint v);
		longint unsigned u;
		longint unsigned q;
		longint unsigned r;
		longint          p;
		u = v + (longint'(1) << 50);
		q = u >> 25;
		r = u & 64'h1FF_FFFF;
		if (r > 64'h100_0000 || (r == 64'h100_0000 && q[0])) q++;
		p = longint'(q) - (longint'(1) << 25);
		if (p < CORNER_MIN) p = CORNER_MIN;
		if (p > CORNER_MAX) p = CORNER_MAX;
		return p[CORNER_W-1:0];
	endfunction

	function automatic int grid_bound(logic [GRID_REG_W-1:0] g);
		if (g < 1) return 1;
		if (g > DEF_MAX_GRID) return DEF_MAX_GRID;
		return g;
	endfunction

	function automatic int clamp_size(int t);
		if (t < SIZE_MIN) return SIZE_MIN;
		if (t > SIZE_MAX) return SIZE_MAX;
		return t;
	endfunction

	// Decodes one prediction at the current position and steps the position.
	function automatic box_t decode_box(logic [IN_DATA_W-1:0] d);
		int                  gw;
		int                  gh;
		int                  rx;
		int                  ry;
		int                  ro;
		logic [ANCHOR_W-1:0] anc;
		longint unsigned     cx;
		longint unsigned     cy;
		longint unsigned     hw;
		longint unsigned     hh;
		longint unsigned     conf;
		box_t                b;
		gw = grid_bound(grid_w_reg);
		gh = grid_bound(grid_h_reg);
		anc = anchor_reg[anchor_pos];
		rx = $signed(d[0*IN_W +: IN_W]);
		ry = $signed(d[1*IN_W +: IN_W]);
		ro = $signed(d[4*IN_W +: IN_W]);
		cx = ((longint'(col_pos) << 16) + logistic_q16(rx)) * stride_x_reg << 9;
		cy = ((longint'(row_pos) << 16) + logistic_q16(ry)) * stride_y_reg << 9;
		hw = exp_fixed(clamp_size($signed(d[2*IN_W +: IN_W]))) * anc[ANCHOR_W-1:ANCHOR_H_BITS];
		hh = exp_fixed(clamp_size($signed(d[3*IN_W +: IN_W]))) * anc[ANCHOR_H_BITS-1:0];
		conf = logistic_q16(ro);
		if (conf > 65535) conf = 65535;
		b.left       = round_corner(longint'(cx) - longint'(hw));
		b.top        = round_corner(longint'(cy) - longint'(hh));
		b.right      = round_corner(longint'(cx) + longint'(hw));
		b.bottom     = round_corner(longint'(cy) + longint'(hh));
		b.confidence = conf[CONF_W-1:0];
		b.last       = (anchor_pos == DEF_ANCHORS_PER_CELL - 1) &&
			(col_pos == gw - 1) && (row_pos == gh - 1);
		anchor_pos++;
		if (anchor_pos >= DEF_ANCHORS_PER_CELL) begin
			anchor_pos = 0;
			col_pos++;
			if (col_pos >= gw) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= gh) row_pos = 0;
			end
		end
		return b;
	endfunction

	function automatic logic [IN_W-1:0] rand_logit();
		case ($urandom_range(0, 4))
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(0, 4096)) - 2048);
			2: return 16'(int'($urandom_range(0, 12288)) - 8192);
			3: return 16'(int'($urandom_range(0, 32768)) - 16384);
			default: begin
				case ($urandom_range(0, 5))
					0:       return 16'h8000;
					1:       return 16'h7FFF;
					2:       return 16'h0000;
					3:       return 16'h1000;
					4:       return 16'hE000;
					default: return 16'hC000;
				endcase
			end
		endcase
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			if (errors < MAX_REPORTS)
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic set_pacing(pacing_t p);
		case (p)
			PACE_RECV_HEAVY: begin
				send_idle_pct = 29;
				recv_idle_pct = 45;
			end
			PACE_SEND_HEAVY: begin
				send_idle_pct = 45;
				recv_idle_pct = 29;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance
	// with tvalid still high, so a following call can keep the stream going.
	task automatic send_item(logic [IN_DATA_W-1:0] d, logic typed, box_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tdata   <= d;
		row_typed = typed;
		row_want  = want;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_GRID_WIDTH:  grid_w_reg    = val[GRID_REG_W-1:0];
			REG_GRID_HEIGHT: grid_h_reg    = val[GRID_REG_W-1:0];
			REG_STRIDE_X:    stride_x_reg  = val[STRIDE_W-1:0];
			REG_STRIDE_Y:    stride_y_reg  = val[STRIDE_W-1:0];
			REG_ANCHOR_ZERO: anchor_reg[0] = val[ANCHOR_W-1:0];
			REG_ANCHOR_ONE:  anchor_reg[1] = val[ANCHOR_W-1:0];
			REG_ANCHOR_TWO:  anchor_reg[2] = val[ANCHOR_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_regs(phase_t p);
		if (p.random_anchors) begin
			p.anchor0 = $urandom_range(0, ANCHOR_TOP);
			p.anchor1 = $urandom_range(0, ANCHOR_TOP);
			p.anchor2 = $urandom_range(0, ANCHOR_TOP);
		end
		write_reg(REG_GRID_WIDTH, CFG_DATA_W'(p.grid_w));
		write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(p.grid_h));
		write_reg(REG_STRIDE_X, CFG_DATA_W'(p.stride_x));
		write_reg(REG_STRIDE_Y, CFG_DATA_W'(p.stride_y));
		write_reg(REG_ANCHOR_ZERO, p.anchor0);
		write_reg(REG_ANCHOR_ONE, p.anchor1);
		write_reg(REG_ANCHOR_TWO, p.anchor2);
		cfg_write <= 1'b0;
	endtask

	task automatic wait_idle();
		while (box_q.size() != 0) @(negedge clk);
	endtask

	// Receiver: random back-pressure, plus one long hold when the driver asks.
	always @(negedge clk) begin
		if (hold_kick != hold_seen) begin
			hold_seen = hold_kick;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Outputs are checked before the input of the same edge is decoded; with a
	// pipeline this deep the two never refer to the same transaction.
	always @(posedge clk) begin
		box_t got;
		box_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.left       = m_tdata[0*CORNER_W +: CORNER_W];
				got.top        = m_tdata[1*CORNER_W +: CORNER_W];
				got.right      = m_tdata[2*CORNER_W +: CORNER_W];
				got.bottom     = m_tdata[3*CORNER_W +: CORNER_W];
				got.confidence = m_tdata[4*CORNER_W +: CONF_W];
				got.last       = m_tlast;
				if (box_q.size() == 0) begin
					if (errors < MAX_REPORTS)
						$display("%0t: box with nothing expected, expected none, got %h",
							$time, got);
					errors++;
				end else begin
					want = box_q.pop_front();
					check_field("left", want.left, got.left);
					check_field("top", want.top, got.top);
					check_field("right", want.right, got.right);
					check_field("bottom", want.bottom, got.bottom);
					check_field("confidence", want.confidence, got.confidence);
					check_field("last", want.last, got.last);
				end
			end
			if (s_tvalid && s_tready) begin
				want = decode_box(s_tdata);
				box_q.push_back(row_typed ? row_want : want);
			end
		end
	end

	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run limit reached", $time);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		phase_t ph;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_pacing(PACE_RECV_HEAVY);
		for (int i = 0; i < DIR_N; i++)
			send_item({DIRECTED[i].obj, DIRECTED[i].h, DIRECTED[i].w, DIRECTED[i].y,
				DIRECTED[i].x}, DIRECTED[i].typed, DIRECTED[i].want);
		s_tvalid <= 1'b0;
		for (int p = 0; p < PHASE_N; p++) begin
			ph = PHASES[p];
			wait_idle();
			set_regs(ph);
			set_pacing(ph.pacing);
			// The long hold lets the block fill while the sender keeps offering.
			if (ph.hold) hold_kick <= ~hold_kick;
			for (int i = 0; i < ph.items; i++)
				send_item({rand_logit(), rand_logit(), rand_logit(), rand_logit(),
					rand_logit()}, 1'b0, '0);
			s_tvalid <= 1'b0;
		end
		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && box_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
